[src/sorted_wakeup_queue_defines.svh]
// Assertion helpers for the queue RTL.
`ifndef SORTED_WAKEUP_QUEUE_DEFINES_SVH
`define SORTED_WAKEUP_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted_wakeup_queue: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted_wakeup_queue: check failed");

`endif

[src/swq_pkg.sv]
package swq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF = 8;

    localparam int TID_W  = 8;
    localparam int WAKE_W = 32;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_WOKEN  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

endpackage

[src/sorted_wakeup_queue.sv]
// Channel  Dir  tuser      tdata (low bit up)                                tlast
// s_axis   in   func       thread_id[7:0], wake_time[39:8], current_tick[71:40]  -
// m_axis   out  kind       status[0], woken_id[8:1], zero[15:9]             last
//
// Entries sit in a circular RAM in wake order; one 32-bit compare is reused every step.
// Insert: tail-to-head scan over the entries later than the new one, moving one entry
// per cycle, then the status word; a full queue gets only the status word.
// Tick: one word per entry due at the current tick (none when the queue is empty),
// one word per cycle while m_tready is high.
// Input is taken only in idle; a stalled output word holds the sequencer.
// Reset (i_rst_n low, synchronous) empties the queue; RAM contents are not cleared.
`include "sorted_wakeup_queue_defines.svh"

module sorted_wakeup_queue #(
    parameter int DEPTH   = swq_pkg::DEPTH_DEF,
    parameter int ID_BITS = swq_pkg::ID_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // thread_id, wake_time, current_tick
    input  logic        i_s_tuser,   // func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // status, woken_id, zero fill
    output logic        o_m_tuser,   // kind
    output logic        o_m_tlast    // last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = swq_pkg::WAKE_W;
    localparam int TID_W = swq_pkg::TID_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_INS_RD  = 3'd1;
    localparam logic [2:0] ST_INS_CMP = 3'd2;
    localparam logic [2:0] ST_INS_PUT = 3'd3;
    localparam logic [2:0] ST_RESP    = 3'd4;
    localparam logic [2:0] ST_TK_RD   = 3'd5;
    localparam logic [2:0] ST_TK_CMP  = 3'd6;
    localparam logic [2:0] ST_TK_FIN  = 3'd7;

    // logical slot (0 = head) to RAM address
    function automatic logic [IDX_W-1:0] f_phys(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] slot);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(head) + (CNT_W+1)'(slot);
        if (s >= (CNT_W+1)'(DEPTH)) begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [ID_BITS-1:0] f_id_in(input logic [TID_W-1:0] tid);
        logic [ID_BITS-1:0] v;
        for (int b = 0; b < ID_BITS; b++) begin
            v[b] = (b < TID_W) ? tid[b] : 1'b0;
        end
        return v;
    endfunction

    function automatic logic [TID_W-1:0] f_id_out(input logic [ID_BITS-1:0] id);
        logic [TID_W-1:0] v;
        for (int b = 0; b < TID_W; b++) begin
            v[b] = (b < ID_BITS) ? id[b] : 1'b0;
        end
        return v;
    endfunction

    logic [2:0]         r_state,  n_state;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic [IDX_W-1:0]   r_head,   n_head;
    logic [CNT_W-1:0]   r_j,      n_j;
    logic [CNT_W-1:0]   r_k,      n_k;
    logic               r_pend,   n_pend;
    logic [ID_BITS-1:0] r_pend_id, n_pend_id;
    logic [ID_BITS-1:0] r_tid,    n_tid;
    logic [KEY_W-1:0]   r_key,    n_key;
    logic               r_full,   n_full;

    logic               r_out_valid;
    logic               r_out_kind;
    logic               r_out_status;
    logic [TID_W-1:0]   r_out_id;
    logic               r_out_last;

    logic               w_accept;
    logic               w_out_free;
    logic               w_out_load;
    logic               w_out_kind;
    logic               w_out_status;
    logic [TID_W-1:0]   w_out_id;
    logic               w_out_last;

    logic               w_we;
    logic               w_wnew;
    logic [CNT_W-1:0]   w_wslot;
    logic               w_re;
    logic [CNT_W-1:0]   w_rslot;
    logic [KEY_W-1:0]   w_rwake;
    logic [ID_BITS-1:0] w_rid;
    logic               w_le;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    // shared compare: stored wake time against the insert time or the current tick
    assign w_le = (w_rwake <= r_key);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_head       = r_head;
        n_j          = r_j;
        n_k          = r_k;
        n_pend       = r_pend;
        n_pend_id    = r_pend_id;
        n_tid        = r_tid;
        n_key        = r_key;
        n_full       = r_full;
        w_we         = 1'b0;
        w_wnew       = 1'b0;
        w_wslot      = r_j;
        w_re         = 1'b0;
        w_rslot      = '0;
        w_out_load   = 1'b0;
        w_out_kind   = swq_pkg::KIND_WOKEN;
        w_out_status = swq_pkg::STATUS_OK;
        w_out_id     = f_id_out(r_pend_id);
        w_out_last   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_tid = f_id_in(i_s_tdata[7:0]);
                    if (i_s_tuser == swq_pkg::FUNC_INSERT) begin
                        n_key = i_s_tdata[39:8];
                        n_j   = r_count;
                        if (r_count == CNT_W'(DEPTH)) begin
                            n_full  = 1'b1;
                            n_state = ST_RESP;
                        end else begin
                            n_full  = 1'b0;
                            n_state = (r_count == '0) ? ST_INS_PUT : ST_INS_RD;
                        end
                    end else begin
                        n_key   = i_s_tdata[71:40];
                        n_k     = '0;
                        n_pend  = 1'b0;
                        n_state = (r_count == '0) ? ST_IDLE : ST_TK_RD;
                    end
                end
            end
            ST_INS_RD: begin
                w_re    = 1'b1;
                w_rslot = r_j - CNT_W'(1);
                n_state = ST_INS_CMP;
            end
            ST_INS_CMP: begin
                w_we = 1'b1;
                if (!w_le) begin
                    // later entry slides one slot toward the tail
                    n_j = r_j - CNT_W'(1);
                    if (r_j == CNT_W'(1)) begin
                        n_state = ST_INS_PUT;
                    end else begin
                        w_re    = 1'b1;
                        w_rslot = r_j - CNT_W'(2);
                    end
                end else begin
                    w_wnew  = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_state = ST_RESP;
                end
            end
            ST_INS_PUT: begin
                w_we    = 1'b1;
                w_wnew  = 1'b1;
                n_count = r_count + CNT_W'(1);
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (w_out_free) begin
                    w_out_load   = 1'b1;
                    w_out_kind   = swq_pkg::KIND_STATUS;
                    w_out_status = r_full ? swq_pkg::STATUS_FULL : swq_pkg::STATUS_OK;
                    w_out_id     = '0;
                    w_out_last   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_TK_RD: begin
                w_re    = 1'b1;
                w_rslot = r_k;
                n_state = ST_TK_CMP;
            end
            ST_TK_CMP: begin
                if (w_le) begin
                    // one-entry lookahead decides the last mark of the held entry
                    if (!r_pend || w_out_free) begin
                        w_out_load = r_pend;
                        n_pend     = 1'b1;
                        n_pend_id  = w_rid;
                        n_k        = r_k + CNT_W'(1);
                        if ((r_k + CNT_W'(1)) < r_count) begin
                            w_re    = 1'b1;
                            w_rslot = r_k + CNT_W'(1);
                        end else begin
                            n_state = ST_TK_FIN;
                        end
                    end
                end else begin
                    n_state = ST_TK_FIN;
                end
            end
            ST_TK_FIN: begin
                if (!r_pend || w_out_free) begin
                    w_out_load = r_pend;
                    w_out_last = 1'b1;
                    n_pend     = 1'b0;
                    n_head     = f_phys(r_head, r_k);
                    n_count    = r_count - r_k;
                    n_state    = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_pend  <= n_pend;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j       <= n_j;
        r_k       <= n_k;
        r_pend_id <= n_pend_id;
        r_tid     <= n_tid;
        r_key     <= n_key;
        r_full    <= n_full;
        if (w_out_load) begin
            r_out_kind   <= w_out_kind;
            r_out_status <= w_out_status;
            r_out_id     <= w_out_id;
            r_out_last   <= w_out_last;
        end
    end

    swq_store #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (f_phys(r_head, w_wslot)),
        .i_wwake (w_wnew ? r_key : w_rwake),
        .i_wid   (w_wnew ? r_tid : w_rid),
        .i_re    (w_re),
        .i_raddr (f_phys(r_head, w_rslot)),
        .o_rwake (w_rwake),
        .o_rid   (w_rid)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {7'd0, r_out_id, r_out_status};

    `SWQ_ASSERT_NEXT(a_full_keeps_count, i_clk, i_rst_n,
        w_accept && (i_s_tuser == swq_pkg::FUNC_INSERT) && (r_count == CNT_W'(DEPTH)),
        (r_count == $past(r_count)) && (r_state == ST_RESP))
    `SWQ_ASSERT_NEXT(a_tick_drains_k, i_clk, i_rst_n,
        (r_state == ST_TK_FIN) && (!r_pend || w_out_free),
        r_count == ($past(r_count) - $past(r_k)))
    `SWQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n,
        (r_state == ST_TK_CMP) || (r_state == ST_INS_CMP),
        (r_count <= CNT_W'(DEPTH)) && (r_k < r_count || r_state == ST_INS_CMP))

endmodule

[src/swq_store.sv]
module swq_store #(
    parameter int DEPTH   = swq_pkg::DEPTH_DEF,
    parameter int ID_BITS = swq_pkg::ID_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  logic [swq_pkg::WAKE_W-1:0]   i_wwake,
    input  logic [ID_BITS-1:0]           i_wid,
    input  logic                         i_re,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr,
    output logic [swq_pkg::WAKE_W-1:0]   o_rwake,
    output logic [ID_BITS-1:0]           o_rid
);

    logic [swq_pkg::WAKE_W-1:0] r_mem_wake [DEPTH];
    logic [ID_BITS-1:0]         r_mem_id   [DEPTH];
    logic [swq_pkg::WAKE_W-1:0] r_rwake;
    logic [ID_BITS-1:0]         r_rid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_wake[i_waddr] <= i_wwake;
            r_mem_id[i_waddr]   <= i_wid;
        end
        if (i_re) begin
            r_rwake <= r_mem_wake[i_raddr];
            r_rid   <= r_mem_id[i_raddr];
        end
    end

    assign o_rwake = r_rwake;
    assign o_rid   = r_rid;

endmodule
